>>> rtl/usb_config_descriptor_parser_core_assert.svh
// assertion macros shared by the parser modules
`ifndef USB_CONFIG_DESCRIPTOR_PARSER_CORE_ASSERT_SVH
`define USB_CONFIG_DESCRIPTOR_PARSER_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define UCDP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ucdp assertion failed");

// next-cycle implication, disabled while in reset
`define UCDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ucdp assertion failed");

`endif

>>> rtl/ucdp_pkg.sv
// types and constants of the configuration descriptor parser
package ucdp_pkg;

    localparam int BYTE_W      = 8;
    localparam int SLOT_W      = 4;
    localparam int KIND_W      = 2;
    localparam int XFER_W      = 2;
    localparam int MAXP_W      = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] TYPE_INTERFACE = 8'd4;
    localparam logic [7:0] TYPE_ENDPOINT  = 8'd5;
    localparam logic [7:0] MIN_HEADER_LEN = 8'd2;
    localparam logic [7:0] XFER_MASK      = 8'h03;

    // byte offsets inside a descriptor
    localparam logic [7:0] POS_HEADER      = 8'd0;
    localparam logic [7:0] POS_TYPE        = 8'd1;
    localparam logic [7:0] POS_IF_NUMBER   = 8'd2;
    localparam logic [7:0] POS_IF_CLASS    = 8'd5;
    localparam logic [7:0] POS_IF_SUBCLASS = 8'd6;
    localparam logic [7:0] POS_IF_PROTOCOL = 8'd7;
    localparam logic [7:0] POS_EP_FIRST    = 8'd2;
    localparam logic [7:0] POS_EP_LAST     = 8'd5;
    localparam logic [7:0] POS_EP_INTERVAL = 8'd6;

    typedef enum logic [KIND_W-1:0] {
        KIND_INTERFACE = 2'd0,
        KIND_ENDPOINT  = 2'd1,
        KIND_END       = 2'd2
    } kind_t;

    // one queue entry: at most one record plus an optional end of block
    typedef struct packed {
        logic                   has_rec;
        logic                   rec_ep;
        logic [SLOT_W-1:0]      if_slot;
        logic [SLOT_W-1:0]      ep_slot;
        logic [3:0][BYTE_W-1:0] fields;
        logic [BYTE_W-1:0]      last;
        logic                   has_end;
        logic [SLOT_W-1:0]      end_count;
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] interface_slot;
        logic [SLOT_W-1:0] endpoint_slot;
        logic [BYTE_W-1:0] interface_number;
        logic [BYTE_W-1:0] interface_class;
        logic [BYTE_W-1:0] subclass_code;
        logic [BYTE_W-1:0] protocol_code;
        logic [BYTE_W-1:0] endpoint_address;
        logic [XFER_W-1:0] transfer_type;
        logic [MAXP_W-1:0] packet_size;
        logic [BYTE_W-1:0] poll_interval;
        logic              run_end;
    } result_t;

endpackage

>>> rtl/ucdp_if.sv
// item channels of the parser: descriptor bytes in, records out
interface ucdp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       block_start;
    logic       block_end;

    modport source (output valid, output data_byte, output block_start, output block_end,
                    input ready);
    modport sink (input valid, input data_byte, input block_start, input block_end,
                  output ready);
endinterface

interface ucdp_record_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  interface_slot;
    logic [3:0]  endpoint_slot;
    logic [7:0]  interface_number;
    logic [7:0]  interface_class;
    logic [7:0]  subclass_code;
    logic [7:0]  protocol_code;
    logic [7:0]  endpoint_address;
    logic [1:0]  transfer_type;
    logic [15:0] packet_size;
    logic [7:0]  poll_interval;
    logic        run_end;

    modport source (output valid, output kind, output interface_slot, output endpoint_slot,
                    output interface_number, output interface_class, output subclass_code,
                    output protocol_code, output endpoint_address, output transfer_type,
                    output packet_size, output poll_interval, output run_end,
                    input ready);
    modport sink (input valid, input kind, input interface_slot, input endpoint_slot,
                  input interface_number, input interface_class, input subclass_code,
                  input protocol_code, input endpoint_address, input transfer_type,
                  input packet_size, input poll_interval, input run_end,
                  output ready);
endinterface

>>> rtl/ucdp_front.sv
// front part: descriptor walker that turns bytes into queue entries
`include "usb_config_descriptor_parser_core_assert.svh"

module ucdp_front #(
    parameter int MAX_INTERFACES = 8,
    parameter int MAX_ENDPOINTS  = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    ucdp_byte_if.sink              bytes,
    input  ucdp_pkg::queue_status_t status,
    output logic                   push,
    output ucdp_pkg::entry_t       push_data
);

    localparam int IW = $clog2(MAX_INTERFACES + 1);
    localparam int EW = $clog2(MAX_ENDPOINTS + 1);

    logic                   stopped_reg, stopped_next;
    logic                   skipping_reg, skipping_next;
    logic [7:0]             pos_reg, pos_next;
    logic [7:0]             len_reg, len_next;
    logic [7:0]             type_reg, type_next;
    logic [IW-1:0]          icount_reg, icount_next;
    logic                   have_if_reg, have_if_next;
    logic [EW-1:0]          ecount_reg, ecount_next;
    logic [3:0][7:0]        cap_reg, cap_next;

    logic                   accept;
    logic [7:0]             d;
    logic                   rec_valid;
    logic                   rec_ep;
    logic [ucdp_pkg::SLOT_W-1:0] rec_if_slot;
    logic [ucdp_pkg::SLOT_W-1:0] rec_ep_slot;
    logic                   stop_now;

    assign bytes.ready = !status.full;
    assign accept      = bytes.valid && bytes.ready;
    assign d           = bytes.data_byte;

    always_comb
    begin
        stopped_next  = stopped_reg;
        skipping_next = skipping_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        type_next     = type_reg;
        icount_next   = icount_reg;
        have_if_next  = have_if_reg;
        ecount_next   = ecount_reg;
        cap_next      = cap_reg;
        rec_valid     = 1'b0;
        rec_ep        = 1'b0;
        rec_if_slot   = '0;
        rec_ep_slot   = '0;
        stop_now      = 1'b0;

        if (accept)
        begin
            if (bytes.block_start)
            begin
                // new block: clear everything, skip the configuration descriptor
                skipping_next = 1'b0;
                pos_next      = '0;
                len_next      = '0;
                type_next     = '0;
                icount_next   = '0;
                have_if_next  = 1'b0;
                ecount_next   = '0;
                cap_next      = '0;
                stopped_next  = (d == 8'd0);
                if (d != 8'd0)
                begin
                    len_next = d;
                    if (d == 8'd1)
                    begin
                        pos_next = '0;
                    end
                    else
                    begin
                        skipping_next = 1'b1;
                        pos_next      = 8'd1;
                    end
                end
            end
            else if (!stopped_reg)
            begin
                if (pos_reg == ucdp_pkg::POS_HEADER)
                begin
                    if (d < ucdp_pkg::MIN_HEADER_LEN)
                    begin
                        stop_now     = 1'b1;
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        len_next  = d;
                        type_next = '0;
                    end
                end
                else if (!skipping_reg)
                begin
                    if (pos_reg == ucdp_pkg::POS_TYPE)
                    begin
                        type_next = d;
                    end
                    else if (type_reg == ucdp_pkg::TYPE_INTERFACE)
                    begin
                        if (pos_reg == ucdp_pkg::POS_IF_NUMBER)
                        begin
                            cap_next[0] = d;
                        end
                        else if (pos_reg == ucdp_pkg::POS_IF_CLASS)
                        begin
                            cap_next[1] = d;
                        end
                        else if (pos_reg == ucdp_pkg::POS_IF_SUBCLASS)
                        begin
                            cap_next[2] = d;
                        end
                        else if (pos_reg == ucdp_pkg::POS_IF_PROTOCOL &&
                                 icount_reg < IW'(MAX_INTERFACES))
                        begin
                            rec_valid    = 1'b1;
                            rec_if_slot  = ucdp_pkg::SLOT_W'(icount_reg);
                            icount_next  = icount_reg + 1'b1;
                            have_if_next = 1'b1;
                            ecount_next  = '0;
                        end
                    end
                    else if (type_reg == ucdp_pkg::TYPE_ENDPOINT)
                    begin
                        if (pos_reg >= ucdp_pkg::POS_EP_FIRST &&
                            pos_reg <= ucdp_pkg::POS_EP_LAST)
                        begin
                            cap_next[pos_reg[1:0] + 2'd2] = d;
                        end
                        else if (pos_reg == ucdp_pkg::POS_EP_INTERVAL && have_if_reg &&
                                 ecount_reg < EW'(MAX_ENDPOINTS))
                        begin
                            rec_valid   = 1'b1;
                            rec_ep      = 1'b1;
                            rec_if_slot = ucdp_pkg::SLOT_W'(icount_reg - 1'b1);
                            rec_ep_slot = ucdp_pkg::SLOT_W'(ecount_reg);
                            ecount_next = ecount_reg + 1'b1;
                        end
                    end
                end

                // step to the next byte, wrapping at the descriptor length
                if (!stop_now)
                begin
                    if ({1'b0, pos_reg} + 9'd1 >= {1'b0, len_next})
                    begin
                        pos_next      = '0;
                        skipping_next = 1'b0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 8'd1;
                    end
                end
            end

            if (bytes.block_end)
            begin
                stopped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stopped_reg  <= 1'b1;
            skipping_reg <= 1'b0;
            pos_reg      <= '0;
            len_reg      <= '0;
            type_reg     <= '0;
            icount_reg   <= '0;
            have_if_reg  <= 1'b0;
            ecount_reg   <= '0;
            cap_reg      <= '0;
        end
        else
        begin
            stopped_reg  <= stopped_next;
            skipping_reg <= skipping_next;
            pos_reg      <= pos_next;
            len_reg      <= len_next;
            type_reg     <= type_next;
            icount_reg   <= icount_next;
            have_if_reg  <= have_if_next;
            ecount_reg   <= ecount_next;
            cap_reg      <= cap_next;
        end
    end

    assign push = accept && (rec_valid || bytes.block_end);

    always_comb
    begin
        push_data           = '0;
        push_data.has_rec   = rec_valid;
        push_data.rec_ep    = rec_ep;
        push_data.if_slot   = rec_if_slot;
        push_data.ep_slot   = rec_ep_slot;
        push_data.fields    = cap_reg;
        push_data.last      = d;
        push_data.has_end   = bytes.block_end;
        push_data.end_count = ucdp_pkg::SLOT_W'(icount_next);
    end

    `UCDP_ASSERT_IMP(a_push_not_full, clk, rst_n, push, !status.full)
    `UCDP_ASSERT_IMP(a_have_if_count, clk, rst_n, have_if_reg, icount_reg != '0)

endmodule

>>> rtl/ucdp_queue.sv
// short entry queue between the walker and the record emitter
`include "usb_config_descriptor_parser_core_assert.svh"

module ucdp_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  ucdp_pkg::entry_t        push_data,
    input  logic                    pop,
    output ucdp_pkg::entry_t        pop_data,
    output ucdp_pkg::queue_status_t status
);

    localparam int PTR_W = $clog2(ucdp_pkg::QUEUE_DEPTH);

    ucdp_pkg::entry_t       slots_reg [ucdp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]         count_reg, count_next;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == (PTR_W + 1)'(ucdp_pkg::QUEUE_DEPTH));
    assign pop_data     = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    `UCDP_ASSERT_IMP(a_pop_not_empty, clk, rst_n, pop, !status.empty)
    `UCDP_ASSERT_NEXT(a_fill_to_full, clk, rst_n,
        push && !pop && count_reg == (PTR_W + 1)'(ucdp_pkg::QUEUE_DEPTH - 1), status.full)

endmodule

>>> rtl/ucdp_back.sv
// back part: expands queue entries into records behind an output register
`include "usb_config_descriptor_parser_core_assert.svh"

module ucdp_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ucdp_pkg::entry_t        head,
    input  ucdp_pkg::queue_status_t status,
    output logic                    pop,
    ucdp_record_if.source           records
);

    typedef enum logic {
        PH_FIRST,
        PH_SECOND
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic              valid_reg, valid_next;
    ucdp_pkg::result_t res_reg, res_next;
    logic              load;

    assign load = !valid_reg || records.ready;

    always_comb
    begin
        phase_next = phase_reg;
        valid_next = valid_reg;
        res_next   = res_reg;
        pop        = 1'b0;

        if (load)
        begin
            valid_next = !status.empty;
            if (!status.empty)
            begin
                res_next = '0;
                if (head.has_rec && phase_reg == PH_FIRST)
                begin
                    // the descriptor record goes out first
                    res_next.interface_slot = head.if_slot;
                    res_next.run_end        = !head.has_end;
                    if (head.rec_ep)
                    begin
                        res_next.kind             = ucdp_pkg::KIND_ENDPOINT;
                        res_next.endpoint_slot    = head.ep_slot;
                        res_next.endpoint_address = head.fields[0];
                        res_next.transfer_type    =
                            ucdp_pkg::XFER_W'(head.fields[1] & ucdp_pkg::XFER_MASK);
                        res_next.packet_size      = {head.fields[3], head.fields[2]};
                        res_next.poll_interval    = head.last;
                    end
                    else
                    begin
                        res_next.kind             = ucdp_pkg::KIND_INTERFACE;
                        res_next.interface_number = head.fields[0];
                        res_next.interface_class  = head.fields[1];
                        res_next.subclass_code    = head.fields[2];
                        res_next.protocol_code    = head.last;
                    end
                    if (head.has_end)
                    begin
                        phase_next = PH_SECOND;
                    end
                    else
                    begin
                        pop = 1'b1;
                    end
                end
                else
                begin
                    // end of block record
                    res_next.kind           = ucdp_pkg::KIND_END;
                    res_next.interface_slot = head.end_count;
                    res_next.run_end        = 1'b1;
                    pop                     = 1'b1;
                    phase_next              = PH_FIRST;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            valid_reg <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
            res_reg   <= res_next;
        end
    end

    assign records.valid            = valid_reg;
    assign records.kind             = res_reg.kind;
    assign records.interface_slot   = res_reg.interface_slot;
    assign records.endpoint_slot    = res_reg.endpoint_slot;
    assign records.interface_number = res_reg.interface_number;
    assign records.interface_class  = res_reg.interface_class;
    assign records.subclass_code    = res_reg.subclass_code;
    assign records.protocol_code    = res_reg.protocol_code;
    assign records.endpoint_address = res_reg.endpoint_address;
    assign records.transfer_type    = res_reg.transfer_type;
    assign records.packet_size      = res_reg.packet_size;
    assign records.poll_interval    = res_reg.poll_interval;
    assign records.run_end          = res_reg.run_end;

    `UCDP_ASSERT_IMP(a_second_has_entry, clk, rst_n, phase_reg == PH_SECOND, !status.empty)
    `UCDP_ASSERT_IMP(a_pop_on_load, clk, rst_n, pop, load && !status.empty)

endmodule

>>> rtl/usb_config_descriptor_parser_core.sv
// USB configuration descriptor parser: takes a configuration descriptor block one
// byte per item and gives interface, endpoint and end-of-block records. The byte
// channel takes one item every cycle as long as the four-entry queue between the
// walker and the record emitter has room; the walker keeps all parser state and
// decides in the cycle of the byte. A byte that yields two records (a record on
// the last byte of a block, plus the end-of-block record) sends them out in turn,
// so the output register sets the sustained rate. A record passes a queue slot,
// then the output register. The leading configuration descriptor is skipped by
// its length, a header length below two stops parsing until the next block_start,
// and bytes outside a block are ignored, but block_end still gives an end record.
// Interface slots and endpoint counts are limited by MAX_INTERFACES and
// MAX_ENDPOINTS; slot fields carry the low four bits of counts.
module usb_config_descriptor_parser_core #(
    parameter int MAX_INTERFACES = 8,
    parameter int MAX_ENDPOINTS  = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    ucdp_byte_if.sink     bytes,
    ucdp_record_if.source records
);

    // queue handshake between front and back
    logic                    push;
    ucdp_pkg::entry_t        push_data;
    logic                    pop;
    ucdp_pkg::entry_t        head;
    ucdp_pkg::queue_status_t status;

    // descriptor walker: header tracking, field capture, slot and endpoint counting
    ucdp_front #(
        .MAX_INTERFACES (MAX_INTERFACES),
        .MAX_ENDPOINTS  (MAX_ENDPOINTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (bytes),
        .status    (status),
        .push      (push),
        .push_data (push_data)
    );

    // decouples byte intake from record delivery
    ucdp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (head),
        .status    (status)
    );

    // record formatting and output register
    ucdp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .status  (status),
        .pop     (pop),
        .records (records)
    );

endmodule

>>> tb/sv/testbench.sv
// self-checking testbench of the usb configuration descriptor parser
module testbench;

    // parser limits, matching the defaults of the core
    localparam int MAX_IFS = 8;
    localparam int MAX_EPS = 16;

    // how a directed row gets its expectation
    typedef enum logic [1:0] {
        FROM_WALKER,
        NO_RECORD,
        END_RECORD
    } row_check_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start_flag;
        logic       end_flag;
        row_check_t check;
        logic [3:0] count;
    } dir_row_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start_flag;
        logic       end_flag;
    } byte_item_t;

    logic clk;
    logic rst_n;

    ucdp_byte_if   byte_ch ();
    ucdp_record_if rec_ch ();

    usb_config_descriptor_parser_core uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (byte_ch),
        .records (rec_ch)
    );

    // shadow copy of the parser state
    logic       w_stopped;
    logic       w_skip_config;
    logic [7:0] w_pos;
    logic [7:0] w_len;
    logic [7:0] w_type;
    int         w_if_count;
    logic       w_have_if;
    int         w_ep_count;
    logic [7:0] w_fields [4];

    ucdp_pkg::result_t expected_records [$];
    int      failures = 0;
    int      src_idle_pct;
    int      snk_stall_pct;

    // directed part: no block open, zero length blocks, one-byte block,
    // a full interface and endpoint with extreme field values, then a
    // header length below two together with the end of block
    dir_row_t dir_rows [26] = '{
        '{8'hFF, 1'b0, 1'b0, NO_RECORD,  4'd0},  // byte before any block
        '{8'h00, 1'b0, 1'b1, END_RECORD, 4'd0},  // end with no open block
        '{8'h00, 1'b1, 1'b0, NO_RECORD,  4'd0},  // zero config length
        '{8'h05, 1'b0, 1'b0, NO_RECORD,  4'd0},  // ignored while stopped
        '{8'h00, 1'b1, 1'b1, END_RECORD, 4'd0},  // one-byte block
        '{8'h01, 1'b1, 1'b0, FROM_WALKER, 4'd0}, // config length one
        '{8'h03, 1'b0, 1'b0, FROM_WALKER, 4'd0}, // short foreign descriptor
        '{8'h21, 1'b0, 1'b0, FROM_WALKER, 4'd0},
        '{8'h00, 1'b0, 1'b0, FROM_WALKER, 4'd0},
        '{8'h09, 1'b0, 1'b0, FROM_WALKER, 4'd0}, // interface descriptor
        '{8'h04, 1'b0, 1'b0, FROM_WALKER, 4'd0},
        '{8'hFF, 1'b0, 1'b0, FROM_WALKER, 4'd0},
        '{8'h00, 1'b0, 1'b0, FROM_WALKER, 4'd0},
        '{8'h00, 1'b0, 1'b0, FROM_WALKER, 4'd0},
        '{8'hFF, 1'b0, 1'b0, FROM_WALKER, 4'd0},
        '{8'h00, 1'b0, 1'b0, FROM_WALKER, 4'd0},
        '{8'hFF, 1'b0, 1'b0, FROM_WALKER, 4'd0},
        '{8'h00, 1'b0, 1'b0, FROM_WALKER, 4'd0},
        '{8'h07, 1'b0, 1'b0, FROM_WALKER, 4'd0}, // endpoint descriptor
        '{8'h05, 1'b0, 1'b0, FROM_WALKER, 4'd0},
        '{8'h81, 1'b0, 1'b0, FROM_WALKER, 4'd0},
        '{8'hFF, 1'b0, 1'b0, FROM_WALKER, 4'd0},
        '{8'hFF, 1'b0, 1'b0, FROM_WALKER, 4'd0},
        '{8'hFF, 1'b0, 1'b0, FROM_WALKER, 4'd0},
        '{8'hFF, 1'b0, 1'b0, FROM_WALKER, 4'd0},
        '{8'h01, 1'b0, 1'b1, END_RECORD, 4'd1}   // header below two, then end
    };

    // clock, period 2
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // clears the shadow parser, as on reset and on block_start
    function automatic void clear_walker();
        w_skip_config = 1'b0;
        w_pos         = '0;
        w_len         = '0;
        w_type        = '0;
        w_if_count    = 0;
        w_have_if     = 1'b0;
        w_ep_count    = 0;
        foreach (w_fields[i])
            w_fields[i] = '0;
    endfunction

    // moves to the next byte of the descriptor, or to the next header
    function automatic void step_position(input logic [7:0] p);
        if (int'(p) + 1 >= int'(w_len))
        begin
            w_pos         = '0;
            w_skip_config = 1'b0;
        end
        else
            w_pos = p + 8'd1;
    endfunction

    // records that one descriptor byte yields, with the state update
    function automatic void walk_descriptor_byte(input logic [7:0] d, input logic start_flag,
                                                 input logic end_flag,
                                                 ref ucdp_pkg::result_t recs[$]);
        ucdp_pkg::result_t rec;
        logic [7:0]        p;
        recs.delete();
        if (start_flag)
        begin
            clear_walker();
            w_stopped = 1'b0;
            if (d == 8'd0)
                w_stopped = 1'b1;
            else
            begin
                w_skip_config = 1'b1;
                w_len         = d;
                step_position(ucdp_pkg::POS_HEADER);
            end
        end
        else if (!w_stopped)
        begin
            p = w_pos;
            if (p == ucdp_pkg::POS_HEADER)
            begin
                if (d < ucdp_pkg::MIN_HEADER_LEN)
                    w_stopped = 1'b1;
                else
                begin
                    w_len  = d;
                    w_type = '0;
                end
            end
            else if (!w_skip_config)
            begin
                if (p == ucdp_pkg::POS_TYPE)
                    w_type = d;
                else if (w_type == ucdp_pkg::TYPE_INTERFACE)
                begin
                    if (p == ucdp_pkg::POS_IF_NUMBER)
                        w_fields[0] = d;
                    else if (p == ucdp_pkg::POS_IF_CLASS)
                        w_fields[1] = d;
                    else if (p == ucdp_pkg::POS_IF_SUBCLASS)
                        w_fields[2] = d;
                    else if (p == ucdp_pkg::POS_IF_PROTOCOL && w_if_count < MAX_IFS)
                    begin
                        rec                  = '0;
                        rec.kind             = ucdp_pkg::KIND_INTERFACE;
                        rec.interface_slot   = ucdp_pkg::SLOT_W'(w_if_count);
                        rec.interface_number = w_fields[0];
                        rec.interface_class  = w_fields[1];
                        rec.subclass_code    = w_fields[2];
                        rec.protocol_code    = d;
                        recs.push_back(rec);
                        w_if_count++;
                        w_have_if  = 1'b1;
                        w_ep_count = 0;
                    end
                end
                else if (w_type == ucdp_pkg::TYPE_ENDPOINT)
                begin
                    if (p >= ucdp_pkg::POS_EP_FIRST && p <= ucdp_pkg::POS_EP_LAST)
                        w_fields[int'(p - ucdp_pkg::POS_EP_FIRST)] = d;
                    else if (p == ucdp_pkg::POS_EP_INTERVAL && w_have_if &&
                             w_ep_count < MAX_EPS)
                    begin
                        rec                  = '0;
                        rec.kind             = ucdp_pkg::KIND_ENDPOINT;
                        rec.interface_slot   = ucdp_pkg::SLOT_W'(w_if_count - 1);
                        rec.endpoint_slot    = ucdp_pkg::SLOT_W'(w_ep_count);
                        rec.endpoint_address = w_fields[0];
                        rec.transfer_type    =
                            ucdp_pkg::XFER_W'(w_fields[1] & ucdp_pkg::XFER_MASK);
                        rec.packet_size      = {w_fields[3], w_fields[2]};
                        rec.poll_interval    = d;
                        recs.push_back(rec);
                        w_ep_count++;
                    end
                end
            end
            if (!w_stopped)
                step_position(p);
        end
        if (end_flag)
        begin
            rec                = '0;
            rec.kind           = ucdp_pkg::KIND_END;
            rec.interface_slot = ucdp_pkg::SLOT_W'(w_if_count);
            recs.push_back(rec);
            w_stopped = 1'b1;
        end
        if (recs.size() > 0)
            recs[recs.size() - 1].run_end = 1'b1;
    endfunction

    // offers one byte, entered and left at a falling edge; the sender may
    // idle first, and on acceptance the expectations are queued
    task automatic send_byte(input logic [7:0] d, input logic start_flag, input logic end_flag,
                             input row_check_t how = FROM_WALKER, input logic [3:0] count = '0);
        ucdp_pkg::result_t recs [$];
        ucdp_pkg::result_t end_rec;
        while ($urandom_range(99) < src_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.data_byte   <= d;
        byte_ch.block_start <= start_flag;
        byte_ch.block_end   <= end_flag;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        // the walker always runs so its state follows the stream
        walk_descriptor_byte(d, start_flag, end_flag, recs);
        case (how)
            FROM_WALKER:
                foreach (recs[i])
                    expected_records.push_back(recs[i]);
            END_RECORD:
            begin
                end_rec                = '0;
                end_rec.kind           = ucdp_pkg::KIND_END;
                end_rec.interface_slot = count;
                end_rec.run_end        = 1'b1;
                expected_records.push_back(end_rec);
            end
            default:
                ;
        endcase
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            failures++;
        end
    endtask

    // receiver stalls at random, rate set by the stimulus phase
    always @(negedge clk)
        rec_ch.ready <= ($urandom_range(99) >= snk_stall_pct);

    // record checker: each accepted record against the oldest expectation
    always @(posedge clk)
    begin
        ucdp_pkg::result_t want;
        if (rst_n && rec_ch.valid && rec_ch.ready)
        begin
            if (expected_records.size() == 0)
            begin
                $display("%0t: unexpected record, expected none, got kind %0d slot %0d",
                         $time, rec_ch.kind, rec_ch.interface_slot);
                failures++;
            end
            else
            begin
                want = expected_records.pop_front();
                check_field("kind", want.kind, rec_ch.kind);
                check_field("interface_slot", want.interface_slot, rec_ch.interface_slot);
                check_field("endpoint_slot", want.endpoint_slot, rec_ch.endpoint_slot);
                check_field("interface_number", want.interface_number,
                            rec_ch.interface_number);
                check_field("interface_class", want.interface_class, rec_ch.interface_class);
                check_field("subclass_code", want.subclass_code, rec_ch.subclass_code);
                check_field("protocol_code", want.protocol_code, rec_ch.protocol_code);
                check_field("endpoint_address", want.endpoint_address,
                            rec_ch.endpoint_address);
                check_field("transfer_type", want.transfer_type, rec_ch.transfer_type);
                check_field("packet_size", want.packet_size, rec_ch.packet_size);
                check_field("poll_interval", want.poll_interval, rec_ch.poll_interval);
                check_field("run_end", want.run_end, rec_ch.run_end);
            end
        end
    end

    // hard limit on the run
    initial
    begin
        #1000000;
        $display("Verification failed");
        $finish;
    end

    // stimulus
    initial
    begin
        byte_item_t blk [$];
        int         items_sent;
        int         phase;
        int         new_phase;
        int         cfg_len;
        int         n_desc;
        int         pick;
        int         dlen;
        int         reps;
        int         if_weight;
        int         cut;
        int         keep;
        logic [7:0] dtype;

        items_sent          = 0;
        phase               = 0;
        src_idle_pct        = 13;
        snk_stall_pct       = 61;
        rst_n               = 1'b0;
        byte_ch.valid       = 1'b0;
        byte_ch.data_byte   = '0;
        byte_ch.block_start = 1'b0;
        byte_ch.block_end   = 1'b0;
        w_stopped           = 1'b1;
        clear_walker();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed rows
        foreach (dir_rows[i])
            send_byte(dir_rows[i].data, dir_rows[i].start_flag, dir_rows[i].end_flag,
                      dir_rows[i].check, dir_rows[i].count);

        // random blocks: mostly well-formed descriptor walks with random content
        while (items_sent < 1300)
        begin
            new_phase = (items_sent < 430) ? 0 : (items_sent < 860) ? 1 : 2;
            if (new_phase != phase)
            begin
                phase = new_phase;
                // hold the sender until every pending record is out
                byte_ch.valid <= 1'b0;
                while (expected_records.size() != 0)
                    @(posedge clk);
                @(negedge clk);
                // second phase swaps the idle rates, third has none
                src_idle_pct  = (phase == 1) ? 61 : 0;
                snk_stall_pct = (phase == 1) ? 13 : 0;
            end

            // stray bytes between blocks
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom), 1'b0, 1'b0);

            blk.delete();
            // leading config descriptor, usually nine bytes
            cfg_len = ($urandom_range(4) != 0) ? 9 : $urandom_range(0, 12);
            blk.push_back('{8'(cfg_len), 1'b1, 1'b0});
            for (int i = 1; i < cfg_len; i++)
                blk.push_back('{8'($urandom), 1'b0, 1'b0});

            // some blocks lean on interfaces to run past the slot limit
            if_weight = ($urandom_range(3) == 0) ? 70 : 35;
            n_desc    = $urandom_range(0, 14);
            for (int k = 0; k < n_desc; k++)
            begin
                pick = $urandom_range(99);
                if (pick < 4)
                    blk.push_back('{8'($urandom_range(1)), 1'b0, 1'b0}); // bad header
                else
                begin
                    reps = 1;
                    if (pick < 4 + if_weight)
                    begin
                        dtype = ucdp_pkg::TYPE_INTERFACE;
                        dlen  = ($urandom_range(9) != 0) ? 9 : $urandom_range(2, 12);
                    end
                    else if (pick < 90)
                    begin
                        dtype = ucdp_pkg::TYPE_ENDPOINT;
                        dlen  = ($urandom_range(9) != 0) ? 7 : $urandom_range(2, 10);
                        // a long run of endpoints to pass the endpoint limit
                        if ($urandom_range(19) == 0)
                            reps = MAX_EPS + 1;
                    end
                    else
                    begin
                        dtype = 8'($urandom);
                        dlen  = ($urandom_range(9) == 0) ? 255 : $urandom_range(2, 20);
                    end
                    repeat (reps)
                    begin
                        blk.push_back('{8'(dlen), 1'b0, 1'b0});
                        blk.push_back('{dtype, 1'b0, 1'b0});
                        for (int i = 2; i < dlen; i++)
                            blk.push_back('{8'($urandom), 1'b0, 1'b0});
                    end
                end
            end

            // most blocks end cleanly, some are cut short, a few never end
            cut = $urandom_range(99);
            if (cut < 8)
            begin
                keep = $urandom_range(1, blk.size());
                while (blk.size() > keep)
                    void'(blk.pop_back());
            end
            if (cut < 92)
                blk[blk.size() - 1].end_flag = 1'b1;

            foreach (blk[i])
                send_byte(blk[i].data, blk[i].start_flag, blk[i].end_flag);
            items_sent += blk.size();
        end
        byte_ch.valid <= 1'b0;

        // drain, then allow for late stray records
        while (expected_records.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl
rtl/ucdp_pkg.sv
rtl/ucdp_if.sv
rtl/ucdp_front.sv
rtl/ucdp_queue.sv
rtl/ucdp_back.sv
rtl/usb_config_descriptor_parser_core.sv
tb/sv/testbench.sv
